[src/dff_pkg.sv]
// shared types and constants of the duplicate frame filter
// no dependencies; imported by every module of the block
`default_nettype none

package dff_pkg;

    localparam int TIME_W    = 64;
    localparam int LEN_W     = 16;
    localparam int KEY_W     = 32;
    localparam int WINDOW_W  = 32;
    localparam int S_DATA_W  = 176;
    localparam int M_DATA_W  = 8;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd2000;

    // one remembered frame
    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [LEN_W-1:0]  length;
        logic [KEY_W-1:0]  key;
    } entry_t;

    // outcome of checking one slot against the current item
    typedef struct packed {
        logic expired;
        logic match;
    } slot_chk_t;

endpackage

`default_nettype wire

[src/duplicate_frame_filter_core.sv]
// time-window duplicate frame filter, top level
// an accepted item is scanned slot by slot, then its result is loaded in the finish state;
//   the scan reads one slot per cycle and stops at the first matching slot
// a new item is taken only in the idle state, once the last result has been loaded;
//   a held result keeps the block in its finish state and s_tready low
// reset: valid bits, insert pointer and handshakes cleared, window_us = 2000;
//   entry memory is not cleared, no start-up pass is needed
`default_nettype none

module duplicate_frame_filter_core
    import dff_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration: window_us
    input  wire logic                cfg_we,
    input  wire logic [WINDOW_W-1:0] cfg_wdata,
    // input items
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // now_us[63:0], len_bytes[79:64], frame_crc[111:80],
    // frame_signature[143:112], size_word[175:144]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // result items
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // is_duplicate[0], zero fill above
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [WINDOW_W-1:0]  window_reg, window_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic                 dup_reg, dup_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_dup_reg, m_dup_next;

    logic                 s_accept;
    logic                 chk_last;
    logic                 live;
    logic                 hit;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;
    entry_t               rd_data;
    slot_chk_t            chk;

    dff_entry_ram #(
        .DEPTH (SLOTS),
        .IDX_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dff_slot_check u_check (
        .now_us    (now_reg),
        .window_us (window_reg),
        .item_len  (len_reg),
        .frame_key (key_reg),
        .entry     (rd_data),
        .chk       (chk)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-1){1'b0}}, m_dup_reg};

    assign chk_last = (chk_idx_reg == LAST_IDX);
    assign live     = valid_reg[chk_idx_reg] && !chk.expired;
    assign hit      = live && chk.match;

    // hit refreshes the time; a miss inserts the same fields at the pointer
    assign wr_data  = '{stamp: now_reg, length: len_reg, key: key_reg};
    assign wr_en    = (state_reg == ST_SCAN) && (hit || chk_last);
    assign wr_addr  = hit ? chk_idx_reg : ptr_reg;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            ST_IDLE: begin
                rd_en   = s_accept;
                rd_addr = '0;
            end
            ST_SCAN: begin
                // read one slot ahead of the one being checked
                rd_en   = !chk_last;
                rd_addr = chk_idx_reg + 1'b1;
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        window_next  = cfg_we ? cfg_wdata : window_reg;
        valid_next   = valid_reg;
        ptr_next     = ptr_reg;
        chk_idx_next = chk_idx_reg;
        now_next     = now_reg;
        len_next     = len_reg;
        key_next     = key_reg;
        dup_next     = dup_reg;
        m_valid_next = (m_valid_reg && m_tready) ? 1'b0 : m_valid_reg;
        m_dup_next   = m_dup_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    now_next     = s_tdata[63:0];
                    len_next     = s_tdata[79:64];
                    key_next     = s_tdata[111:80] ^ s_tdata[143:112] ^ s_tdata[175:144];
                    chk_idx_next = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (valid_reg[chk_idx_reg] && chk.expired) begin
                    valid_next[chk_idx_reg] = 1'b0;
                end
                if (hit) begin
                    dup_next   = 1'b1;
                    state_next = ST_FINISH;
                end else if (chk_last) begin
                    // miss: overwrite the pointed slot whatever it holds
                    valid_next[ptr_reg] = 1'b1;
                    ptr_next   = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                    dup_next   = 1'b0;
                    state_next = ST_FINISH;
                end else begin
                    chk_idx_next = chk_idx_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_dup_next   = dup_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            window_reg  <= WINDOW_RESET;
            valid_reg   <= '0;
            ptr_reg     <= '0;
            chk_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            window_reg  <= window_next;
            valid_reg   <= valid_next;
            ptr_reg     <= ptr_next;
            chk_idx_reg <= chk_idx_next;
            m_valid_reg <= m_valid_next;
        end
        now_reg   <= now_next;
        len_reg   <= len_next;
        key_reg   <= key_next;
        dup_reg   <= dup_next;
        m_dup_reg <= m_dup_next;
    end

`ifndef NO_ASSERTIONS
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside finish");

    a_insert_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && chk_last && !hit) |=> valid_reg[$past(ptr_reg)])
        else $error("inserted slot not marked valid");

    a_dup_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg) && m_dup_reg) |-> (valid_reg != '0))
        else $error("duplicate reported with no live entry");

    a_scan_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (chk_idx_reg <= LAST_IDX))
        else $error("scan index beyond last slot");
`endif

endmodule

`default_nettype wire

[src/dff_entry_ram.sv]
// entry memory: one write port, one read port with registered read data
// depends on dff_pkg for the entry type
`default_nettype none

module dff_entry_ram
    import dff_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/dff_slot_check.sv]
// age and key check of one stored entry against the current item
// depends on dff_pkg for the entry and result types
`default_nettype none

module dff_slot_check
    import dff_pkg::*;
(
    input  wire logic [TIME_W-1:0]   now_us,
    input  wire logic [WINDOW_W-1:0] window_us,
    input  wire logic [LEN_W-1:0]    item_len,
    input  wire logic [KEY_W-1:0]    frame_key,
    input  wire entry_t              entry,
    output slot_chk_t                chk
);

    logic [TIME_W:0] age;

    always_comb begin
        // borrow set means the stored time is ahead of now: age counts as zero
        age = {1'b0, now_us} - {1'b0, entry.stamp};
        chk.expired = !age[TIME_W] &&
                      ((age[TIME_W-1:WINDOW_W] != '0) || (age[WINDOW_W-1:0] > window_us));
        chk.match = (entry.length == item_len) && (entry.key == frame_key);
    end

endmodule

`default_nettype wire
